// ===== rtl/dtg_pkg.sv =====
// Package for the depth to gray converter: shared types and constants.
// No dependencies.
`default_nettype none
package dtg_pkg;
  localparam int unsigned DepthW = 16;
  localparam int unsigned GrayW = 8;
  localparam logic [DepthW-1:0] DepthMax = 16'hffff;
  localparam logic [GrayW-1:0] GrayMax = 8'd255;
  localparam logic [15:0] FullScaleSq = 16'd65025;
  localparam int unsigned QueueDepth = 2;

  // Op codes of the input item.
  localparam logic OpMeasure = 1'b0;
  localparam logic OpConvert = 1'b1;

  // One classified convert job passed from front to back.
  typedef struct packed {
    logic              flat;
    logic [DepthW-1:0] diff;
    logic [DepthW-1:0] range;
    logic              last;
  } job_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_SQRT,
    ST_DONE
  } back_state_t;
endpackage
`default_nettype wire

// ===== rtl/depth_to_gray_sqrt_normalize_core.sv =====
// Top level of the depth to gray converter: front, job queue and back part.
// Depends on dtg_pkg, dtg_front, dtg_queue and dtg_back.
`default_nettype none
// A depth frame is streamed twice. Measure-pass pixels (op = 0) are taken
// every cycle, give no result, and on frame_end latch the frame's minimum
// and range. Convert-pass pixels (op = 1) each give one result,
// gray = 255 - isqrt(65025 * (depth - min) / range), with the difference
// clamped into the range and a zero range giving 255. In the back part a
// convert pixel is loaded, passes through a restoring divider and a square
// root, and is handed off to the output register; a flat frame skips the
// divider and the square root. Each convert transfer writes its job into
// the queue, from which the back part takes it. The two-entry queue lets
// the front keep taking pixels while the back works and a finished result
// waits.
module depth_to_gray_sqrt_normalize_core (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        op,
  input  wire logic [15:0] depth,
  input  wire logic        frame_end,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [7:0]       gray,
  output logic             last
);
  import dtg_pkg::*;

  job_t f_job, b_job;
  logic f_valid, f_ready, b_valid, b_ready;

  dtg_front u_front (
    .clk, .rst, .in_valid, .in_ready, .op, .depth, .frame_end,
    .job_valid(f_valid), .job_ready(f_ready), .job(f_job)
  );

  dtg_queue u_queue (
    .clk, .rst, .wr_valid(f_valid), .wr_ready(f_ready), .wr_data(f_job),
    .rd_valid(b_valid), .rd_ready(b_ready), .rd_data(b_job)
  );

  dtg_back u_back (
    .clk, .rst, .job_valid(b_valid), .job_ready(b_ready), .job(b_job),
    .out_valid, .out_ready, .gray, .last
  );
endmodule
`default_nettype wire

// ===== rtl/dtg_front.sv =====
// Front part: takes pixels, tracks min/max in the measure pass, and builds
// clamped convert jobs. Depends on dtg_pkg.
`default_nettype none
module dtg_front (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire logic          op,
  input  wire logic [15:0]   depth,
  input  wire logic          frame_end,
  output logic               job_valid,
  input  wire logic          job_ready,
  output dtg_pkg::job_t      job
);
  import dtg_pkg::*;

  logic [DepthW-1:0] running_min, running_max, latched_min, latched_range;
  logic [DepthW-1:0] mn, mx, diff;
  logic take;

  assign in_ready = (op == OpMeasure) ? 1'b1 : job_ready;
  assign take = in_valid && in_ready;
  assign job_valid = in_valid && (op == OpConvert);

  always_comb begin
    mn = (depth < running_min) ? depth : running_min;
    mx = (depth > running_max) ? depth : running_max;
    diff = (depth > latched_min) ? depth - latched_min : '0;
    if (diff > latched_range) diff = latched_range;
    job.flat = (latched_range == '0);
    job.diff = diff;
    job.range = latched_range;
    job.last = frame_end;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running_min <= DepthMax;
      running_max <= '0;
      latched_min <= '0;
      latched_range <= '0;
    end else if (take && op == OpMeasure) begin
      if (frame_end) begin
        latched_min <= mn;
        latched_range <= (mx >= mn) ? mx - mn : '0;
        running_min <= DepthMax;
        running_max <= '0;
      end else begin
        running_min <= mn;
        running_max <= mx;
      end
    end
  end
endmodule
`default_nettype wire

// ===== rtl/dtg_queue.sv =====
// Short job queue between front and back parts. Depends on dtg_pkg.
`default_nettype none
module dtg_queue (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     wr_valid,
  output logic          wr_ready,
  input  dtg_pkg::job_t wr_data,
  output logic          rd_valid,
  input  wire logic     rd_ready,
  output dtg_pkg::job_t rd_data
);
  import dtg_pkg::*;

  job_t slot [QueueDepth];
  logic wp, rp;
  logic [1:0] count;

  assign wr_ready = (count != 2'(QueueDepth));
  assign rd_valid = (count != '0);
  assign rd_data = slot[rp];

  always_ff @(posedge clk) begin
    if (wr_valid && wr_ready) slot[wp] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= 1'b0;
      rp <= 1'b0;
      count <= '0;
    end else begin
      if (wr_valid && wr_ready) wp <= ~wp;
      if (rd_valid && rd_ready) rp <= ~rp;
      count <= count + 2'(wr_valid && wr_ready) - 2'(rd_valid && rd_ready);
    end
  end
endmodule
`default_nettype wire

// ===== rtl/dtg_back.sv =====
// Back part: restoring divider then bit-pair square root, one step a cycle,
// with an output register. Depends on dtg_pkg.
`default_nettype none
module dtg_back (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     job_valid,
  output logic          job_ready,
  input  dtg_pkg::job_t job,
  output logic          out_valid,
  input  wire logic     out_ready,
  output logic [7:0]    gray,
  output logic          last
);
  import dtg_pkg::*;

  back_state_t state, state_next;
  logic [31:0] num;          // dividend shifting out, quotient shifting in
  logic [15:0] rem;
  logic [15:0] den;
  logic [4:0]  step;
  logic [15:0] rad;          // radicand, two bits a step
  logic [7:0]  sq_rem;
  logic [7:0]  root;
  logic        flat, last_q;
  logic [16:0] rem_sh;
  logic [9:0]  trial;
  logic [9:0]  sq_sh;
  logic        free;

  assign free = !out_valid || out_ready;
  assign job_ready = (state == ST_IDLE);
  assign rem_sh = {rem, num[31]};
  assign sq_sh = {sq_rem, rad[15:14]};
  assign trial = {root, 2'b01};

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: if (job_valid) state_next = job.flat ? ST_DONE : ST_DIV;
      ST_DIV:  if (step == 5'd31) state_next = ST_SQRT;
      ST_SQRT: if (step == 5'd7) state_next = ST_DONE;
      ST_DONE: if (free) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else state <= state_next;
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        num <= 32'(FullScaleSq) * 32'(job.diff);
        den <= job.range;
        rem <= '0;
        step <= '0;
        flat <= job.flat;
        last_q <= job.last;
        sq_rem <= '0;
        root <= '0;
      end
      ST_DIV: begin
        step <= step + 5'd1;
        if (rem_sh >= {1'b0, den}) begin
          rem <= 16'(rem_sh - {1'b0, den});
          num <= {num[30:0], 1'b1};
        end else begin
          rem <= rem_sh[15:0];
          num <= {num[30:0], 1'b0};
        end
        if (step == 5'd31) begin
          step <= '0;
        end
      end
      ST_SQRT: begin
        step <= step + 5'd1;
        rad <= {rad[13:0], 2'b00};
        // The remainder that matters fits eight bits; only the last one is wider.
        if (sq_sh >= trial) begin
          sq_rem <= 8'(sq_sh - trial);
          root <= {root[6:0], 1'b1};
        end else begin
          sq_rem <= sq_sh[7:0];
          root <= {root[6:0], 1'b0};
        end
      end
      default: ;
    endcase
    // The quotient is at most 65025, so its low 16 bits are the radicand.
    if (state == ST_DIV && step == 5'd31) rad <= {num[14:0], (rem_sh >= {1'b0, den})};
  end

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (state == ST_DONE && free) out_valid <= 1'b1;
    else if (out_ready) out_valid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (state == ST_DONE && free) begin
      gray <= flat ? GrayMax : GrayMax - root;
      last <= last_q;
    end
  end
endmodule
`default_nettype wire

// ===== rtl/depth_to_gray_sqrt_normalize_core_checker.sv =====
// Port-level checker for the depth to gray converter, bound to the top.
// Depends on depth_to_gray_sqrt_normalize_core.
`default_nettype none
module dtg_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       in_valid,
  input wire logic       in_ready,
  input wire logic       op,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [7:0] gray,
  input wire logic       last
);
  a_measure_ready: assert property (@(posedge clk) disable iff (rst)
    in_valid && !op |-> in_ready) else $error("measure pixel stalled");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(gray) && $stable(last))
    else $error("result changed while stalled");
  a_reset_idle: assert property (@(posedge clk)
    $past(rst) |-> !out_valid) else $error("result after reset");
endmodule

bind depth_to_gray_sqrt_normalize_core dtg_checker u_checker (
  .clk, .rst, .in_valid, .in_ready, .op, .out_valid, .out_ready, .gray, .last
);
`default_nettype wire
